[src/assert_macros.svh]
// Assertion macros used by the checker file of the motion filter.
// Depends on nothing; the including scope provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define MMF_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define MMF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/mmf_pkg.sv]
// Shared types, constants and helpers of the mouse motion filter.
// Depends on nothing; used by every module of the block.
`default_nettype none

package mmf_pkg;

    localparam int DEF_HISTORY_DEPTH = 10;
    localparam int DEF_FRACTION_BITS = 8;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 24;
    localparam int DIR_W      = 2;
    localparam int WEIGHT_W   = 17;
    localparam int FACTOR_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int WIDE_W     = 48;

    localparam logic [WEIGHT_W-1:0] UNITY_WEIGHT  = 17'h1_0000;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET  = 16'd13107;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 48'sh7F_FFFF;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -48'sh80_0000;

    localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_BACK = 2'sb11;
    localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ENABLE,
        REG_WEIGHT_FACTOR
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic mac;
        logic drain;
        logic div_start;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Clamp a wide signed value to the signed 24-bit output range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[OUT_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/mmf_divider.sv]
// Restoring divider, one quotient bit per cycle while i_step is high, truncating toward zero.
// Depends on mmf_pkg.
`default_nettype none

module mmf_divider
    import mmf_pkg::*;
#(
    parameter int NUM_W     = 38,
    parameter int DEN_W     = 21,
    parameter int FRAC_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_start,
    input  wire logic                           i_step,
    input  wire logic signed [NUM_W-1:0]        i_num,
    input  wire logic        [DEN_W-1:0]        i_den,
    output logic signed [SAMPLE_W+FRAC_BITS:0]  o_quot
);

    localparam int QW  = SAMPLE_W + FRAC_BITS;
    localparam int DVW = NUM_W + FRAC_BITS;

    logic [NUM_W-1:0] mag;
    logic [DVW-1:0]   dvd_full;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    logic [DEN_W-1:0] r_rem;
    logic [QW-1:0]    r_dvd;   // dividend bits going out, quotient bits coming in
    logic             r_neg;

    always_comb begin
        mag      = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        dvd_full = DVW'(mag) << FRAC_BITS;
        trial    = {r_rem, r_dvd[QW-1]};
        diff     = trial - {1'b0, i_den};
        fits     = (trial >= {1'b0, i_den});
    end

    // Top part of the scaled dividend is below the divisor, so only QW steps remain.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(dvd_full >> QW);
            r_dvd <= dvd_full[QW-1:0];
            r_neg <= i_num[NUM_W-1];
        end else if (i_step) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_dvd <= {r_dvd[QW-2:0], fits};
        end
    end

    assign o_quot = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});

endmodule

`default_nettype wire

[src/mmf_datapath.sv]
// Datapath: history lines, shared weight multiply-accumulate, two dividers,
// smoothing and the output register. Depends on mmf_pkg and mmf_divider.
`default_nettype none

module mmf_datapath
    import mmf_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_dp_cmd                     i_cmd,
    output t_dp_status                       o_status,
    input  wire logic signed [SAMPLE_W-1:0]  i_motion_x,
    input  wire logic signed [SAMPLE_W-1:0]  i_motion_y,
    input  wire logic signed [SAMPLE_W-1:0]  i_wheel_count,
    input  wire logic                        i_filter_enable,
    input  wire logic [FACTOR_W-1:0]         i_weight_factor,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic signed [OUT_W-1:0]          o_filtered_x,
    output logic signed [OUT_W-1:0]          o_filtered_y,
    output logic signed [DIR_W-1:0]          o_wheel_direction
);

    localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(HISTORY_DEPTH);
    localparam int TOT_W  = WEIGHT_W + $clog2(HISTORY_DEPTH);
    localparam int QW     = SAMPLE_W + FRACTION_BITS;

    logic signed [SAMPLE_W-1:0] r_hist_x [HISTORY_DEPTH];
    logic signed [SAMPLE_W-1:0] r_hist_y [HISTORY_DEPTH];
    logic signed [OUT_W-1:0]    r_prev_x;
    logic signed [OUT_W-1:0]    r_prev_y;
    logic                       r_out_valid;

    logic                        r_filt;
    logic [WEIGHT_W-1:0]         r_w;
    logic [TOT_W-1:0]            r_total;
    logic signed [PROD_W-1:0]    r_prod_x;
    logic signed [PROD_W-1:0]    r_prod_y;
    logic signed [ACC_W-1:0]     r_acc_x;
    logic signed [ACC_W-1:0]     r_acc_y;
    logic signed [OUT_W-1:0]     r_raw_x;
    logic signed [OUT_W-1:0]     r_raw_y;
    logic signed [DIR_W-1:0]     r_wheel;
    logic signed [OUT_W-1:0]     r_out_x;
    logic signed [OUT_W-1:0]     r_out_y;
    logic signed [DIR_W-1:0]     r_out_dir;

    logic [WEIGHT_W+FACTOR_W-1:0] w_prod;
    logic [WEIGHT_W-1:0]          w_next;
    logic signed [PROD_W-1:0]     prod_x;
    logic signed [PROD_W-1:0]     prod_y;
    logic signed [QW:0]           quot_x;
    logic signed [QW:0]           quot_y;
    logic signed [OUT_W-1:0]      avg_x;
    logic signed [OUT_W-1:0]      avg_y;
    logic signed [OUT_W:0]        sum_x;
    logic signed [OUT_W:0]        sum_y;
    logic signed [OUT_W:0]        adj_x;
    logic signed [OUT_W:0]        adj_y;
    logic                         out_free;

    always_comb begin
        w_prod   = r_w * i_weight_factor;
        w_next   = w_prod[WEIGHT_W+FACTOR_W-1:FACTOR_W];
        prod_x   = r_hist_x[0] * $signed({1'b0, r_w});
        prod_y   = r_hist_y[0] * $signed({1'b0, r_w});
        avg_x    = sat_out(WIDE_W'(quot_x));
        avg_y    = sat_out(WIDE_W'(quot_y));
        sum_x    = (OUT_W+1)'(avg_x) + (OUT_W+1)'(r_prev_x);
        sum_y    = (OUT_W+1)'(avg_y) + (OUT_W+1)'(r_prev_y);
        // bias negative sums by one so the halving truncates toward zero
        adj_x    = sum_x + (OUT_W+1)'(sum_x[OUT_W]);
        adj_y    = sum_y + (OUT_W+1)'(sum_y[OUT_W]);
        out_free = !r_out_valid || i_out_ready;
    end

    // History lines: shift in on a filtered item, rotate once per tap during the sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist_x[i] <= '0;
                r_hist_y[i] <= '0;
            end
        end else if (i_cmd.load && i_filter_enable) begin
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
                r_hist_x[i] <= r_hist_x[i-1];
                r_hist_y[i] <= r_hist_y[i-1];
            end
            r_hist_x[0] <= i_motion_x;
            r_hist_y[0] <= i_motion_y;
        end else if (i_cmd.mac) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist_x[i] <= r_hist_x[(i + 1) % HISTORY_DEPTH];
                r_hist_y[i] <= r_hist_y[(i + 1) % HISTORY_DEPTH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish && r_filt) begin
                r_prev_x <= avg_x;
                r_prev_y <= avg_y;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Multiply-accumulate: product registered, added to the accumulator in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_filt   <= i_filter_enable;
            r_w      <= UNITY_WEIGHT;
            r_total  <= '0;
            r_prod_x <= '0;
            r_prod_y <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_raw_x  <= sat_out(WIDE_W'(i_motion_x) <<< FRACTION_BITS);
            r_raw_y  <= sat_out(WIDE_W'(i_motion_y) <<< FRACTION_BITS);
            r_wheel  <= i_wheel_count[SAMPLE_W-1] ? DIR_BACK :
                        ((|i_wheel_count) ? DIR_FWD : DIR_NONE);
        end else if (i_cmd.mac) begin
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
            r_acc_x  <= r_acc_x + ACC_W'(r_prod_x);
            r_acc_y  <= r_acc_y + ACC_W'(r_prod_y);
            r_total  <= r_total + TOT_W'(r_w);
            r_w      <= w_next;
        end else if (i_cmd.drain) begin
            r_acc_x  <= r_acc_x + ACC_W'(r_prod_x);
            r_acc_y  <= r_acc_y + ACC_W'(r_prod_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_x   <= r_filt ? adj_x[OUT_W:1] : r_raw_x;
            r_out_y   <= r_filt ? adj_y[OUT_W:1] : r_raw_y;
            r_out_dir <= r_wheel;
        end
    end

    mmf_divider #(
        .NUM_W     (ACC_W),
        .DEN_W     (TOT_W),
        .FRAC_BITS (FRACTION_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_start (i_cmd.div_start),
        .i_step  (i_cmd.div_step),
        .i_num   (r_acc_x),
        .i_den   (r_total),
        .o_quot  (quot_x)
    );

    mmf_divider #(
        .NUM_W     (ACC_W),
        .DEN_W     (TOT_W),
        .FRAC_BITS (FRACTION_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_start (i_cmd.div_start),
        .i_step  (i_cmd.div_step),
        .i_num   (r_acc_y),
        .i_den   (r_total),
        .o_quot  (quot_y)
    );

    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_filtered_x      = r_out_x;
    assign o_filtered_y      = r_out_y;
    assign o_wheel_direction = r_out_dir;

endmodule

`default_nettype wire

[src/mmf_ctrl.sv]
// Controller: sequences load, tap accumulation, division and result hand-off.
// Depends on mmf_pkg.
`default_nettype none

module mmf_ctrl
    import mmf_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_filter_enable,
    input  wire t_dp_status i_status,
    output logic            o_ready,
    output t_dp_cmd         o_cmd
);

    localparam int QW      = SAMPLE_W + FRACTION_BITS;
    localparam int CNT_MAX = (HISTORY_DEPTH > QW) ? HISTORY_DEPTH : QW;
    localparam int CNT_W   = $clog2(CNT_MAX);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;

    assign accept = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = i_filter_enable ? ST_MAC : ST_FINISH;
                end
            end
            ST_MAC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HISTORY_DEPTH - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_cnt   = '0;
                n_state = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_ready          = (r_state == ST_IDLE);
        o_cmd            = '0;
        o_cmd.load       = accept;
        o_cmd.mac        = (r_state == ST_MAC);
        o_cmd.drain      = (r_state == ST_DRAIN);
        o_cmd.div_start  = (r_state == ST_DIV_INIT);
        o_cmd.div_step   = (r_state == ST_DIV);
        o_cmd.finish     = (r_state == ST_FINISH) && i_status.out_free;
    end

endmodule

`default_nettype wire

[src/mouse_motion_filter_unit.sv]
// Mouse motion filter top level: configuration registers, controller, datapath.
// Depends on mmf_pkg, mmf_ctrl, mmf_datapath (and mmf_divider below it).
//
// Usage:
//  - Input channel (i_valid / o_ready) takes one mouse report: X, Y motion and
//    wheel count. Output channel (o_valid / i_ready) gives one result per report:
//    filtered X and Y (signed, FRACTION_BITS fraction bits) and wheel direction.
//  - With filtering on, an item goes from acceptance through one step per history
//    tap in the shared multiply-accumulate, one drain step, one divider load, one
//    step per quotient bit and the write of the output register; the controller
//    then returns to idle for the next acceptance. The result shows right after
//    that write. With filtering off an item goes from acceptance straight to the
//    output register write.
//  - The output register parts the two sides: a new item is accepted while a
//    result still waits. When the receiver stalls, the finished item holds in
//    the controller until the output register frees up.
//  - Reset (synchronous, active low) clears both history lines and the previous
//    averages, drops any pending result, and sets filter_enable to 1 and
//    weight_factor to 13107. Write configuration only while the block is idle.
`default_nettype none

module mouse_motion_filter_unit
    import mmf_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write port
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    // report input
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [SAMPLE_W-1:0]   i_motion_x,
    input  wire logic signed [SAMPLE_W-1:0]   i_motion_y,
    input  wire logic signed [SAMPLE_W-1:0]   i_wheel_count,
    // filtered output
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [OUT_W-1:0]           o_filtered_x,
    output logic signed [OUT_W-1:0]           o_filtered_y,
    output logic signed [DIR_W-1:0]           o_wheel_direction
);

    logic                r_filter_enable;
    logic [FACTOR_W-1:0] r_weight_factor;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Configuration registers; writes outside the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b1;
            r_weight_factor <= FACTOR_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FILTER_ENABLE: r_filter_enable <= i_cfg_data[0];
                REG_WEIGHT_FACTOR: r_weight_factor <= i_cfg_data[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mmf_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_filter_enable (r_filter_enable),
        .i_status        (status),
        .o_ready         (o_ready),
        .o_cmd           (cmd)
    );

    mmf_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_motion_x        (i_motion_x),
        .i_motion_y        (i_motion_y),
        .i_wheel_count     (i_wheel_count),
        .i_filter_enable   (r_filter_enable),
        .i_weight_factor   (r_weight_factor),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_filtered_x      (o_filtered_x),
        .o_filtered_y      (o_filtered_y),
        .o_wheel_direction (o_wheel_direction)
    );

endmodule

`default_nettype wire

[src/mmf_checker.sv]
// Port-level checks of the motion filter, bound to the top level.
// Depends on mmf_pkg, assert_macros.svh and mouse_motion_filter_unit.
`default_nettype none

`include "assert_macros.svh"

module mmf_checker
    import mmf_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_ready,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic signed [OUT_W-1:0]    o_filtered_x,
    input wire logic signed [OUT_W-1:0]    o_filtered_y,
    input wire logic signed [DIR_W-1:0]    o_wheel_direction
);

    // a stalled result holds
    `MMF_ASSERT_CLK(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_filtered_x) && $stable(o_filtered_y) && $stable(o_wheel_direction), "stalled result changed")

    // wheel direction is never the unused code
    `MMF_ASSERT_CLK(a_dir_code, o_valid |-> o_wheel_direction != 2'b10, "bad wheel direction code")

    // one item at a time: ready drops right after an acceptance
    `MMF_ASSERT_CLK(a_one_item, i_valid && o_ready |=> !o_ready, "second item taken while busy")

    // reset drops any pending result
    `MMF_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind mouse_motion_filter_unit mmf_checker u_mmf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_filtered_x      (o_filtered_x),
    .o_filtered_y      (o_filtered_y),
    .o_wheel_direction (o_wheel_direction)
);

`default_nettype wire
